// ===== design/rwas_pkg.sv =====
// ----------------------------------------------------------------------------
// rwas_pkg
// Shared types and constants for the replay window and ack scheduler.
// ----------------------------------------------------------------------------
package rwas_pkg;

  localparam int SEQ_W    = 48;
  localparam int CNT_W    = 4;
  localparam int ADDR_W   = 4;
  localparam int PDATA_W  = 32;

  localparam logic [CNT_W-1:0] UNACKED_MAX = 4'd15;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_WRAP   = 2'd1,
    ST_OLD    = 2'd2,
    ST_DUP    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TMR_NONE      = 2'd0,
    TMR_DELAYED   = 2'd1,
    TMR_IMMEDIATE = 2'd2
  } timer_e;

  typedef enum logic [2:0] {
    PK_DROP   = 3'd0,
    PK_FLUSH  = 3'd1,
    PK_CONTIG = 3'd2,
    PK_GAP    = 3'd3,
    PK_LATE   = 3'd4
  } pkt_kind_e;

  typedef enum logic [1:0] {
    REG_DELAY_ACK_EN = 2'd0,
    REG_DATA_ACK_THR = 2'd1,
    REG_ACK_ONLY_THR = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic             delay_ack_enable;
    logic [CNT_W-1:0] data_ack_threshold;
    logic [CNT_W-1:0] ack_only_threshold;
  } cfg_t;

  typedef struct packed {
    pkt_kind_e        kind;
    status_e          status;
    logic [SEQ_W-1:0] full_seq;
    logic [SEQ_W-1:0] highest_seq;
  } win_info_t;

  typedef struct packed {
    timer_e           timer_action;
    logic             flush_valid;
    logic [SEQ_W-1:0] flush_seq;
    logic [CNT_W-1:0] flush_count;
    logic             direct_ack_valid;
    logic [SEQ_W-1:0] direct_ack_seq;
  } ack_res_t;

endpackage

// ===== design/rwas_regs.sv =====
// ----------------------------------------------------------------------------
// rwas_regs
// APB register file holding the delayed-ack enable and the ack scheduling thresholds.
// ----------------------------------------------------------------------------
module rwas_regs import rwas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[ADDR_W-1:2])
        REG_DELAY_ACK_EN: cfg_d.delay_ack_enable   = pwdata[0];
        REG_DATA_ACK_THR: cfg_d.data_ack_threshold = pwdata[CNT_W-1:0];
        REG_ACK_ONLY_THR: cfg_d.ack_only_threshold = pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_DELAY_ACK_EN: prdata = PDATA_W'(cfg_q.delay_ack_enable);
      REG_DATA_ACK_THR: prdata = PDATA_W'(cfg_q.data_ack_threshold);
      REG_ACK_ONLY_THR: prdata = PDATA_W'(cfg_q.ack_only_threshold);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ack_enable   <= 1'b1;
      cfg_q.data_ack_threshold <= 4'd2;
      cfg_q.ack_only_threshold <= 4'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/rwas_window.sv =====
// ----------------------------------------------------------------------------
// rwas_window
// Sequence extension, replay check and sliding window state.
// ----------------------------------------------------------------------------
module rwas_window import rwas_pkg::*; #(
  parameter int WINDOW_BITS    = 32,
  parameter int SEQ_FIELD_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      update_i,
  input  logic                      req_type_i,
  input  logic [SEQ_FIELD_BITS-1:0] seq_field_i,
  output win_info_t                 info_o
);

  localparam int IW = $clog2(WINDOW_BITS);

  logic [SEQ_W-1:0]          highest_q, highest_d;
  logic [WINDOW_BITS-1:0]    mask_q, mask_d;
  logic [SEQ_FIELD_BITS-1:0] raw;
  logic [SEQ_FIELD_BITS-1:0] mag;
  logic                      neg;
  logic [SEQ_W-1:0]          mag_ext;
  logic [SEQ_W:0]            sum;
  logic [SEQ_W:0]            diff;
  logic [SEQ_W-1:0]          pkt;
  logic                      mag_zero;
  logic                      mag_one;
  logic                      mag_lt_w;
  logic [IW-1:0]             mag_idx;

  always_comb begin
    raw      = seq_field_i - highest_q[SEQ_FIELD_BITS-1:0];
    neg      = raw[SEQ_FIELD_BITS-1];
    mag      = neg ? (SEQ_FIELD_BITS'(0) - raw) : raw;
    mag_ext  = SEQ_W'(mag);
    sum      = {1'b0, highest_q} + {1'b0, mag_ext};
    diff     = {1'b0, highest_q} - {1'b0, mag_ext};
    pkt      = neg ? diff[SEQ_W-1:0] : sum[SEQ_W-1:0];
    mag_zero = (mag == '0);
    mag_one  = (mag == SEQ_FIELD_BITS'(1));
    mag_lt_w = (mag < SEQ_FIELD_BITS'(WINDOW_BITS));
    mag_idx  = mag[IW-1:0];
  end

  always_comb begin
    info_o.highest_seq = highest_q;
    info_o.full_seq    = pkt;
    info_o.status      = ST_ACCEPT;
    info_o.kind        = PK_LATE;
    if (req_type_i) begin
      info_o.kind     = PK_FLUSH;
      info_o.full_seq = '0;
    end else if (!neg && !mag_zero) begin
      if (sum[SEQ_W]) begin
        info_o.kind   = PK_DROP;
        info_o.status = ST_WRAP;
      end else begin
        info_o.kind = mag_one ? PK_CONTIG : PK_GAP;
      end
    end else if (neg && !mag_lt_w) begin
      info_o.kind   = PK_DROP;
      info_o.status = ST_OLD;
    end else if (neg && diff[SEQ_W]) begin
      info_o.kind   = PK_DROP;
      info_o.status = ST_WRAP;
    end else if (mask_q[mag_idx]) begin
      info_o.kind   = PK_DROP;
      info_o.status = ST_DUP;
    end
  end

  always_comb begin
    highest_d = highest_q;
    mask_d    = mask_q;
    if (update_i) begin
      case (info_o.kind)
        PK_CONTIG: begin
          highest_d = pkt;
          mask_d    = {mask_q[WINDOW_BITS-2:0], 1'b1};
        end
        PK_GAP: begin
          highest_d = pkt;
          mask_d    = mag_lt_w ? ((mask_q << mag_idx) | WINDOW_BITS'(1)) : WINDOW_BITS'(1);
        end
        PK_LATE: mask_d = mask_q | (WINDOW_BITS'(1) << mag_idx);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q <= '0;
      mask_q    <= WINDOW_BITS'(1);
    end else begin
      highest_q <= highest_d;
      mask_q    <= mask_d;
    end
  end

endmodule

// ===== design/rwas_ack.sv =====
// ----------------------------------------------------------------------------
// rwas_ack
// Ack counters, timer arming and ack action decision per packet.
// ----------------------------------------------------------------------------
module rwas_ack import rwas_pkg::*; #(
  parameter int ACK_COUNT_MAX = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      update_i,
  input  cfg_t      cfg_i,
  input  logic      ack_wanted_i,
  input  win_info_t info_i,
  output ack_res_t  res_o
);

  localparam int CW = $clog2(ACK_COUNT_MAX + 1);

  logic [CW-1:0]    contig_q, contig_d, contig_inc;
  logic [CNT_W-1:0] unacked_q, unacked_d, unacked_inc;
  logic             armed_q, armed_d;
  logic [CW-1:0]    flush_cnt_sel;
  logic [CW+3:0]    flush_cnt_ext;
  logic             at_limit;
  logic             do_flush;

  always_comb begin
    contig_inc  = (contig_q < CW'(ACK_COUNT_MAX)) ? contig_q + CW'(1) : contig_q;
    unacked_inc = (unacked_q < UNACKED_MAX) ? unacked_q + CNT_W'(1) : unacked_q;
    at_limit    = (unacked_inc >= cfg_i.ack_only_threshold);
  end

  always_comb begin
    contig_d           = contig_q;
    unacked_d          = unacked_q;
    armed_d            = armed_q;
    do_flush           = 1'b0;
    flush_cnt_sel      = contig_q;
    res_o.timer_action = TMR_NONE;
    res_o.flush_valid  = 1'b0;
    res_o.flush_seq    = '0;
    res_o.direct_ack_valid = 1'b0;
    res_o.direct_ack_seq   = '0;

    case (info_i.kind)
      PK_CONTIG: begin
        contig_d  = contig_inc;
        unacked_d = unacked_inc;
        if (at_limit) begin
          do_flush          = 1'b1;
          flush_cnt_sel     = contig_inc;
          res_o.flush_valid = (unacked_inc != '0);
          res_o.flush_seq   = info_i.full_seq;
        end else if (ack_wanted_i) begin
          if (cfg_i.delay_ack_enable && (unacked_inc < cfg_i.data_ack_threshold)) begin
            if (!armed_q) begin
              res_o.timer_action = TMR_DELAYED;
              armed_d            = 1'b1;
            end
          end else begin
            res_o.timer_action = TMR_IMMEDIATE;
            armed_d            = 1'b1;
          end
        end
      end
      PK_GAP, PK_LATE, PK_FLUSH: begin
        do_flush          = 1'b1;
        res_o.flush_valid = (unacked_q != '0);
        res_o.flush_seq   = info_i.highest_seq;
        if (info_i.kind == PK_GAP) begin
          contig_d = '0;
        end
        if (info_i.kind != PK_FLUSH && ack_wanted_i) begin
          res_o.direct_ack_valid = 1'b1;
          res_o.direct_ack_seq   = info_i.full_seq;
        end
      end
      default: ;
    endcase

    if (do_flush) begin
      unacked_d = '0;
      armed_d   = 1'b0;
    end
    if (!res_o.flush_valid) begin
      res_o.flush_seq = '0;
    end

    flush_cnt_ext     = {4'b0000, flush_cnt_sel};
    res_o.flush_count = res_o.flush_valid ? flush_cnt_ext[CNT_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contig_q  <= '0;
      unacked_q <= '0;
      armed_q   <= 1'b0;
    end else if (update_i) begin
      contig_q  <= contig_d;
      unacked_q <= unacked_d;
      armed_q   <= armed_d;
    end
  end

endmodule

// ===== design/replay_window_ack_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// replay_window_ack_scheduler_top
// Receive-side anti-replay window with delayed and immediate ack scheduling.
// ----------------------------------------------------------------------------
// One word is accepted every clock cycle while in_stall_o is low: the word
// is captured in an input register, then the sequence
// extension, replay check and ack decision run in one pass and land in the
// result register while the window, mask and counters update at the same
// edge. The loop through the 48-bit extension adder and the
// mask shift sets the throughput of one word per cycle when nothing stalls. Stall on the result
// side backs up through both registers.
module replay_window_ack_scheduler_top import rwas_pkg::*; #(
  parameter int WINDOW_BITS    = 32,
  parameter int SEQ_FIELD_BITS = 24,
  parameter int ACK_COUNT_MAX  = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,

  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [SEQ_FIELD_BITS-1:0] seq_field_i,
  input  logic                      ack_wanted_i,

  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [SEQ_W-1:0]          full_seq_o,
  output logic [1:0]                timer_action_o,
  output logic                      flush_valid_o,
  output logic [SEQ_W-1:0]          flush_seq_o,
  output logic [CNT_W-1:0]          flush_count_o,
  output logic                      direct_ack_valid_o,
  output logic [SEQ_W-1:0]          direct_ack_seq_o
);

  cfg_t      cfg;
  win_info_t win_info;
  ack_res_t  ack_res;

  logic                      in_valid_q;
  logic                      req_type_q;
  logic [SEQ_FIELD_BITS-1:0] seq_field_q;
  logic                      ack_wanted_q;

  logic                      out_valid_q;
  status_e                   status_q;
  logic [SEQ_W-1:0]          full_seq_q;
  ack_res_t                  res_q;

  logic out_ready;
  logic fire;
  logic in_load;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_load    = in_valid_i && !in_stall_o;

  rwas_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rwas_window #(
    .WINDOW_BITS    (WINDOW_BITS),
    .SEQ_FIELD_BITS (SEQ_FIELD_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (fire),
    .req_type_i  (req_type_q),
    .seq_field_i (seq_field_q),
    .info_o      (win_info)
  );

  rwas_ack #(
    .ACK_COUNT_MAX (ACK_COUNT_MAX)
  ) u_ack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .update_i     (fire),
    .cfg_i        (cfg),
    .ack_wanted_i (ack_wanted_q),
    .info_i       (win_info),
    .res_o        (ack_res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      req_type_q   <= req_type_i;
      seq_field_q  <= seq_field_i;
      ack_wanted_q <= ack_wanted_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q   <= win_info.status;
      full_seq_q <= win_info.full_seq;
      res_q      <= ack_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign full_seq_o         = full_seq_q;
  assign timer_action_o     = res_q.timer_action;
  assign flush_valid_o      = res_q.flush_valid;
  assign flush_seq_o        = res_q.flush_seq;
  assign flush_count_o      = res_q.flush_count;
  assign direct_ack_valid_o = res_q.direct_ack_valid;
  assign direct_ack_seq_o   = res_q.direct_ack_seq;

  // dropped words carry no ack action
  a_drop_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_ACCEPT) |->
      !flush_valid_o && !direct_ack_valid_o && (timer_action_o == TMR_NONE))
    else $error("dropped word carries an ack action");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side can advance");

  a_flush_no_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flush_valid_o |-> (timer_action_o == TMR_NONE))
    else $error("flush and timer start in the same word");

  a_direct_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && direct_ack_valid_o |-> (direct_ack_seq_o == full_seq_o))
    else $error("direct ack sequence differs from packet sequence");

endmodule
